// File: rtl/core/pdcp_pkg.sv
// ----------------------------------------------------------------------------
// pdcp_pkg
// Shared constants and a latency helper for the phase-doubled cross product.
// ----------------------------------------------------------------------------
package pdcp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRONT_STAGES     = 5;

    // cycles from an accepted input transfer to its result being offered
    function automatic int pdcp_latency(input int sw);
        return FRONT_STAGES + 2 * sw + 2 * sw + 1;
    endfunction

endpackage

// File: rtl/core/pdcp_if.sv
// ----------------------------------------------------------------------------
// pdcp_in_if / pdcp_out_if
// Valid/ready channels for sample pairs and phase-doubled results.
// ----------------------------------------------------------------------------
interface pdcp_in_if #(
    parameter int SW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] first_re;
    logic signed [SW-1:0] first_im;
    logic signed [SW-1:0] second_re;
    logic signed [SW-1:0] second_im;
    logic                 last_in;

    modport source (output valid, first_re, first_im, second_re, second_im, last_in,
                    input ready);
    modport sink   (input valid, first_re, first_im, second_re, second_im, last_in,
                    output ready);
endinterface

interface pdcp_out_if #(
    parameter int SW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [2*SW:0] out_re;
    logic signed [2*SW:0] out_im;
    logic                 last_out;

    modport source (output valid, out_re, out_im, last_out, input ready);
    modport sink   (input valid, out_re, out_im, last_out, output ready);
endinterface

// File: rtl/core/pdcp_front.sv
// ----------------------------------------------------------------------------
// pdcp_front
// Cross product, magnitudes, squares and numerators in five stages.
// ----------------------------------------------------------------------------
module pdcp_front
    import pdcp_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [SW-1:0] ar,
    input  logic signed [SW-1:0] ai,
    input  logic signed [SW-1:0] br,
    input  logic signed [SW-1:0] bi,
    input  logic                 last_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4*SW-1:0]      n_sum,
    output logic [4*SW-1:0]      num_re,
    output logic [4*SW-1:0]      num_im,
    output logic                 re_neg,
    output logic                 im_neg,
    output logic                 last_out
);

    localparam int N  = FRONT_STAGES;
    localparam int PW = 2 * SW;
    localparam int ZW = 2 * SW + 1;
    localparam int MW = 2 * SW;
    localparam int QW = 4 * SW;

    logic [N-1:0] v_reg;
    logic [N:0]   en;
    logic [N-1:0] last_reg;

    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [ZW-1:0] zr_reg, zi_reg;
    logic [MW-1:0]        mr_reg, mi_reg;
    logic                 zr_neg_reg, zi_neg_reg;
    logic                 sn3_reg;
    logic [QW-1:0]        r2_reg, i2_reg, p_reg;
    logic [QW-1:0]        n_reg, nre_reg, nim_reg;
    logic                 rneg_reg, ineg_reg;

    logic [QW-1:0] nre_next, nim_next;
    logic          rneg_next, ineg_next;

    assign en[N] = out_ready;
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < N; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        rneg_next = r2_reg < i2_reg;
        nre_next  = rneg_next ? (i2_reg - r2_reg) : (r2_reg - i2_reg);
        nim_next  = {p_reg[QW-2:0], 1'b0};
        ineg_next = sn3_reg && (nim_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg      <= ar * br;
            pb_reg      <= ai * bi;
            pc_reg      <= ar * bi;
            pd_reg      <= br * ai;
            last_reg[0] <= last_in;
        end
        if (en[1])
        begin
            zr_reg      <= ZW'(pa_reg) + ZW'(pb_reg);
            zi_reg      <= ZW'(pc_reg) - ZW'(pd_reg);
            last_reg[1] <= last_reg[0];
        end
        if (en[2])
        begin
            mr_reg      <= zr_reg[ZW-1] ? MW'(-zr_reg) : MW'(zr_reg);
            mi_reg      <= zi_reg[ZW-1] ? MW'(-zi_reg) : MW'(zi_reg);
            zr_neg_reg  <= zr_reg[ZW-1];
            zi_neg_reg  <= zi_reg[ZW-1];
            last_reg[2] <= last_reg[1];
        end
        if (en[3])
        begin
            r2_reg      <= QW'(mr_reg) * QW'(mr_reg);
            i2_reg      <= QW'(mi_reg) * QW'(mi_reg);
            p_reg       <= QW'(mr_reg) * QW'(mi_reg);
            sn3_reg     <= zr_neg_reg != zi_neg_reg;
            last_reg[3] <= last_reg[2];
        end
        if (en[4])
        begin
            n_reg       <= r2_reg + i2_reg;
            nre_reg     <= nre_next;
            nim_reg     <= nim_next;
            rneg_reg    <= rneg_next;
            ineg_reg    <= ineg_next;
            last_reg[4] <= last_reg[3];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign n_sum     = n_reg;
    assign num_re    = nre_reg;
    assign num_im    = nim_reg;
    assign re_neg    = rneg_reg;
    assign im_neg    = ineg_reg;
    assign last_out  = last_reg[N-1];

endmodule

// File: rtl/core/pdcp_isqrt.sv
// ----------------------------------------------------------------------------
// pdcp_isqrt
// Pipelined floored square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pdcp_isqrt
    import pdcp_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [4*SW-1:0]   n_sum,
    input  logic [4*SW-1:0]   num_re,
    input  logic [4*SW-1:0]   num_im,
    input  logic              re_neg,
    input  logic              im_neg,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2*SW-1:0]   root,
    output logic [4*SW-1:0]   num_re_out,
    output logic [4*SW-1:0]   num_im_out,
    output logic              re_neg_out,
    output logic              im_neg_out,
    output logic              last_out
);

    localparam int NW   = 4 * SW;
    localparam int RW   = 2 * SW;
    localparam int REMW = RW + 3;

    logic [RW-1:0] v_reg;
    logic [RW:0]   en;

    logic [NW-1:0]   n_reg   [RW];
    logic [REMW-1:0] rem_reg [RW];
    logic [RW-1:0]   root_reg[RW];
    logic [NW-1:0]   nre_reg [RW];
    logic [NW-1:0]   nim_reg [RW];
    logic [RW-1:0]   rneg_reg, ineg_reg, last_reg;

    assign en[RW] = out_ready;

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [NW-1:0]   n_prev, nre_prev, nim_prev;
            logic [REMW-1:0] rem_prev, cur, trial, rem_next;
            logic [RW-1:0]   root_prev, root_next;
            logic            rneg_prev, ineg_prev, last_prev, v_prev;

            if (k == 0) begin : g_first
                assign n_prev    = n_sum;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign nre_prev  = num_re;
                assign nim_prev  = num_im;
                assign rneg_prev = re_neg;
                assign ineg_prev = im_neg;
                assign last_prev = last_in;
                assign v_prev    = in_valid;
            end else begin : g_next
                assign n_prev    = n_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign nre_prev  = nre_reg[k-1];
                assign nim_prev  = nim_reg[k-1];
                assign rneg_prev = rneg_reg[k-1];
                assign ineg_prev = ineg_reg[k-1];
                assign last_prev = last_reg[k-1];
                assign v_prev    = v_reg[k-1];
            end

            assign en[k] = !v_reg[k] || en[k+1];

            always_comb
            begin
                cur   = {rem_prev[REMW-3:0], n_prev[NW-1 -: 2]};
                trial = REMW'({root_prev, 2'b01});
                if (cur >= trial)
                begin
                    rem_next  = cur - trial;
                    root_next = {root_prev[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = cur;
                    root_next = {root_prev[RW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    n_reg[k]    <= {n_prev[NW-3:0], 2'b00};
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    nre_reg[k]  <= nre_prev;
                    nim_reg[k]  <= nim_prev;
                    rneg_reg[k] <= rneg_prev;
                    ineg_reg[k] <= ineg_prev;
                    last_reg[k] <= last_prev;
                end
            end
        end
    endgenerate

    assign in_ready   = en[0];
    assign out_valid  = v_reg[RW-1];
    assign root       = root_reg[RW-1];
    assign num_re_out = nre_reg[RW-1];
    assign num_im_out = nim_reg[RW-1];
    assign re_neg_out = rneg_reg[RW-1];
    assign im_neg_out = ineg_reg[RW-1];
    assign last_out   = last_reg[RW-1];

endmodule

// File: rtl/core/pdcp_div.sv
// ----------------------------------------------------------------------------
// pdcp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pdcp_div
    import pdcp_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [4*SW-1:0]   num,
    input  logic [2*SW-1:0]   den,
    input  logic              neg_in,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2*SW:0]     quot,
    output logic [2*SW-1:0]   den_out,
    output logic              neg_out,
    output logic              last_out
);

    localparam int NW = 4 * SW;
    localparam int RW = 2 * SW;
    localparam int QW = 2 * SW + 1;

    logic [QW-1:0] v_reg;
    logic [QW:0]   en;

    logic [NW-1:0] rem_reg[QW];
    logic [QW-1:0] q_reg  [QW];
    logic [RW-1:0] d_reg  [QW];
    logic [QW-1:0] neg_reg, last_reg;

    assign en[QW] = out_ready;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [NW-1:0] rem_prev, sh, rem_next;
            logic [QW-1:0] q_prev;
            logic [RW-1:0] d_prev;
            logic          neg_prev, last_prev, v_prev, bit_q;

            if (k == 0) begin : g_first
                assign rem_prev  = num;
                assign q_prev    = '0;
                assign d_prev    = den;
                assign neg_prev  = neg_in;
                assign last_prev = last_in;
                assign v_prev    = in_valid;
            end else begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign q_prev    = q_reg[k-1];
                assign d_prev    = d_reg[k-1];
                assign neg_prev  = neg_reg[k-1];
                assign last_prev = last_reg[k-1];
                assign v_prev    = v_reg[k-1];
            end

            assign en[k] = !v_reg[k] || en[k+1];

            always_comb
            begin
                sh       = NW'(d_prev) << (QW - 1 - k);
                bit_q    = rem_prev >= sh;
                rem_next = bit_q ? (rem_prev - sh) : rem_prev;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= rem_next;
                    q_reg[k]    <= {q_prev[QW-2:0], bit_q};
                    d_reg[k]    <= d_prev;
                    neg_reg[k]  <= neg_prev;
                    last_reg[k] <= last_prev;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign den_out   = d_reg[QW-1];
    assign neg_out   = neg_reg[QW-1];
    assign last_out  = last_reg[QW-1];

endmodule

// File: rtl/core/phase_doubled_cross_product.sv
// ----------------------------------------------------------------------------
// phase_doubled_cross_product
// z = conj(a)*b, out z*z/floor(|z|), one sample pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel, one transfer per pair of complex samples a, b
//            plus the last marker of the array.
//   result : source channel, one transfer per sample pair, in order.
// Throughput: one transfer per cycle unless result stalls, set by a fully
//   pipelined datapath of five arithmetic stages, a square root of one root
//   bit per stage and two parallel dividers of one quotient bit per stage.
// Every stage has its own valid bit and advances when it is empty or the
//   next stage advances, so a stalled receiver fills the pipe from the
//   output backwards and nothing is dropped or repeated; empty stages keep
//   taking input while a result waits.
// Reset clears all valid bits; no results are pending after reset.
// A zero cross product gives a zero result.
// ----------------------------------------------------------------------------
module phase_doubled_cross_product
    import pdcp_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pdcp_in_if.sink    sample,
    pdcp_out_if.source result
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = 4 * SW;
    localparam int RW = 2 * SW;
    localparam int QW = 2 * SW + 1;

    logic          f_valid, f_ready;
    logic [NW-1:0] f_n, f_nre, f_nim;
    logic          f_rneg, f_ineg, f_last;

    logic          s_valid, s_ready;
    logic [RW-1:0] s_root;
    logic [NW-1:0] s_nre, s_nim;
    logic          s_rneg, s_ineg, s_last;

    logic          dr_ready, di_ready, dr_valid, di_valid;
    logic [QW-1:0] dr_q, di_q;
    logic [RW-1:0] dr_d, di_d;
    logic          dr_neg, di_neg, dr_last, di_last;

    pdcp_front #(.SW(SW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .ar        (sample.first_re),
        .ai        (sample.first_im),
        .br        (sample.second_re),
        .bi        (sample.second_im),
        .last_in   (sample.last_in),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .n_sum     (f_n),
        .num_re    (f_nre),
        .num_im    (f_nim),
        .re_neg    (f_rneg),
        .im_neg    (f_ineg),
        .last_out  (f_last)
    );

    pdcp_isqrt #(.SW(SW)) u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .n_sum      (f_n),
        .num_re     (f_nre),
        .num_im     (f_nim),
        .re_neg     (f_rneg),
        .im_neg     (f_ineg),
        .last_in    (f_last),
        .out_valid  (s_valid),
        .out_ready  (s_ready),
        .root       (s_root),
        .num_re_out (s_nre),
        .num_im_out (s_nim),
        .re_neg_out (s_rneg),
        .im_neg_out (s_ineg),
        .last_out   (s_last)
    );

    // both dividers run in lockstep
    assign s_ready = dr_ready && di_ready;

    pdcp_div #(.SW(SW)) u_div_re (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (dr_ready),
        .num       (s_nre),
        .den       (s_root),
        .neg_in    (s_rneg),
        .last_in   (s_last),
        .out_valid (dr_valid),
        .out_ready (result.ready),
        .quot      (dr_q),
        .den_out   (dr_d),
        .neg_out   (dr_neg),
        .last_out  (dr_last)
    );

    pdcp_div #(.SW(SW)) u_div_im (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (di_ready),
        .num       (s_nim),
        .den       (s_root),
        .neg_in    (s_ineg),
        .last_in   (s_last),
        .out_valid (di_valid),
        .out_ready (result.ready),
        .quot      (di_q),
        .den_out   (di_d),
        .neg_out   (di_neg),
        .last_out  (di_last)
    );

    always_comb
    begin
        result.valid    = dr_valid && di_valid;
        result.last_out = dr_last && di_last;
        if (dr_d == '0)
        begin
            result.out_re = '0;
        end
        else
        begin
            result.out_re = dr_neg ? -$signed(dr_q) : $signed(dr_q);
        end
        if (di_d == '0)
        begin
            result.out_im = '0;
        end
        else
        begin
            result.out_im = di_neg ? -$signed(di_q) : $signed(di_q);
        end
    end

endmodule

// File: rtl/core/pdcp_checker.sv
// ----------------------------------------------------------------------------
// pdcp_checker
// Port-level checks on stalled results and pipeline occupancy.
// ----------------------------------------------------------------------------
module pdcp_checker
    import pdcp_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [2*SW:0] out_re
);

    localparam int DEPTH = pdcp_latency(SW);
    localparam int CW    = $clog2(DEPTH + 1) + 1;

    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_re))
        else $error("result dropped or changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result offered with no transfer in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("more transfers in flight than pipeline stages");

endmodule

bind phase_doubled_cross_product pdcp_checker #(.SW(SAMPLE_WIDTH)) u_pdcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_re    (result.out_re)
);
